### hw/rtl/ihl_pkg.sv
// Shared types, constants and digit decode for the hex record loader.
// No dependencies; imported by every module of the block.
package ihl_pkg;

  localparam int unsigned PosW = 10;
  localparam logic [PosW-1:0] PosIdle = 10'd1023;
  localparam logic [PosW-1:0] PosData = 10'd9;
  localparam logic [PosW-1:0] PosEnd  = 10'd520;

  localparam logic [7:0] StartCode = 8'h3A;
  localparam logic [7:0] TypeData  = 8'h00;
  localparam logic [7:0] TypeEof   = 8'h01;
  localparam logic [7:0] TypeLoMax = 8'h05;

  typedef enum logic [2:0] {
    KIND_WRITE    = 3'd0,
    KIND_NO_START = 3'd1,
    KIND_EOF      = 3'd2,
    KIND_UNSUPP   = 3'd3,
    KIND_UNKNOWN  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [16:0] write_addr;
    logic [7:0]  write_data;
    logic [7:0]  rec_type;
  } result_t;

  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v;
  endfunction

endpackage

### hw/rtl/ihl_parser.sv
// Record line parser: position counter, header fields and result decode.
// Depends on ihl_pkg.
module ihl_parser
  import ihl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  logic [7:0] char_i,
  input  logic       line_start_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [PosW-1:0] pos_q, pos_d, p_eff;
  logic [7:0]      bc_q, bc_d, bc_eff;
  logic [15:0]     ba_q, ba_d, ba_eff;
  logic [7:0]      rk_q, rk_d, rk_eff;
  logic [7:0]      ph_q, ph_d, ph_eff;
  logic [7:0]      v, b;
  logic [8:0]      idx_w;
  logic [7:0]      idx;
  logic            active;

  always_comb begin
    p_eff  = line_start_i ? '0 : pos_q;
    bc_eff = line_start_i ? '0 : bc_q;
    ba_eff = line_start_i ? '0 : ba_q;
    rk_eff = line_start_i ? '0 : rk_q;
    ph_eff = line_start_i ? '0 : ph_q;
    active = (p_eff != PosIdle) && (p_eff < PosEnd);
    v      = nibble_of(char_i);
    b      = {ph_eff[3:0], 4'b0000} | v;
    idx_w  = p_eff[PosW-1:1] - 9'd5;
    idx    = idx_w[7:0];

    pos_d = p_eff;
    bc_d  = bc_eff;
    ba_d  = ba_eff;
    rk_d  = rk_eff;
    ph_d  = ph_eff;

    res_valid_o      = 1'b0;
    res_o.kind       = KIND_WRITE;
    res_o.write_addr = '0;
    res_o.write_data = '0;
    res_o.rec_type   = rk_eff;

    if (active) begin
      pos_d = p_eff + 10'd1;
      if (p_eff == '0) begin
        if (char_i != StartCode) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_NO_START;
        end
      end else if (p_eff[0]) begin
        ph_d = v;
      end else if (p_eff == 10'd2) begin
        bc_d = b;
      end else if (p_eff == 10'd4) begin
        ba_d = {b, 8'h00};
      end else if (p_eff == 10'd6) begin
        ba_d = {ba_eff[15:8], b};
      end else if (p_eff == 10'd8) begin
        rk_d           = b;
        res_o.rec_type = b;
        if (b == TypeEof) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_EOF;
        end else if (b > TypeEof && b <= TypeLoMax) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_UNSUPP;
        end else if (b != TypeData) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_UNKNOWN;
        end
      end else if (p_eff > PosData) begin
        if (rk_eff == TypeData && idx < bc_eff) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_WRITE;
          res_o.write_addr = {1'b0, ba_eff} + {9'd0, idx};
          res_o.write_data = b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosIdle;
      bc_q  <= '0;
      ba_q  <= '0;
      rk_q  <= '0;
      ph_q  <= '0;
    end else if (go_i) begin
      pos_q <= pos_d;
      bc_q  <= bc_d;
      ba_q  <= ba_d;
      rk_q  <= rk_d;
      ph_q  <= ph_d;
    end
  end

endmodule

### hw/rtl/ihl_out_fifo.sv
// Two-entry result buffer between the parser and the output channel.
// Depends on ihl_pkg.
module ihl_out_fifo
  import ihl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  always_comb begin
    full_o      = (cnt_q == 2'd2);
    out_valid_o = (cnt_q != 2'd0);
    out_data_o  = mem_q[rd_ptr_q];
    pop         = out_valid_o && !out_stall_i;
    wr_ptr_d    = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d    = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d       = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### hw/rtl/intel_hex_record_loader.sv
// Top level of the hex record loader: input register, parser, result buffer.
// Depends on ihl_pkg, ihl_parser and ihl_out_fifo.
//
// Input channel: one character word per accepted transfer (in_valid_i high,
// in_stall_o low), with line_start_i marking the first character of a line.
// Output channel: zero or one result word per character; kind_o gives a data
// write, a missing start code, end of file, or an unsupported/unknown type.
// Order: an accepted character is held in the input register, and its result
// is written into the two-entry result buffer, which drives out_valid_o.
// Throughput: one character per cycle unless stalled; the parser is a single
// pass of nibble decode and position update between input register and the
// buffer. in_stall_o rises only when the buffer holds two results that the
// receiver has not taken while a character waits in the input register.
// Reset: no line is active, all header fields are zero, both registers are
// empty; characters before the first line start are dropped.
module intel_hex_record_loader
  import ihl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        line_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [16:0] write_addr_o,
  output logic [7:0]  write_data_o,
  output logic [7:0]  rec_type_o
);

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       ls_q;
  logic       full;
  logic       go;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  assign go         = in_valid_q && !full;
  assign in_stall_o = in_valid_q && full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_in_i;
      ls_q   <= line_start_i;
    end
  end

  ihl_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .char_i      (char_q),
    .line_start_i(ls_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ihl_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (go && res_valid),
    .push_data_i(res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign kind_o       = out_data.kind;
  assign write_addr_o = out_data.write_addr;
  assign write_data_o = out_data.write_data;
  assign rec_type_o   = out_data.rec_type;

endmodule

### tb/sv/tb_intel_hex_record_loader.sv
// Self-checking testbench for intel_hex_record_loader: feeds record-line characters
// under random bursts and output stalls, and predicts every result word in place.
// Depends on ihl_pkg and the loader RTL only.
`timescale 1ns / 100ps

module tb_intel_hex_record_loader;
  import ihl_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       first;
  } hex_char_t;

  typedef enum int {RX_FREE, RX_COIN, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_in = 8'h00;
  logic        line_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [16:0] write_addr;
  logic [7:0]  write_data;
  logic [7:0]  rec_type;

  hex_char_t line_chars[$];
  result_t   record_events[$];

  logic [9:0]  line_pos;
  logic [7:0]  rec_count;
  logic [15:0] rec_addr;
  logic [7:0]  cur_type;
  logic [7:0]  high_nib;

  int n_queued = 0;
  int n_accepted = 0;
  int n_bad = 0;
  int kind_seen[5] = '{default: 0};
  int burst_left;
  int gap_left;
  int stall_cyc;
  bit holding;
  bit stray_ok = 1'b0;
  rx_mode_e rx_mode = RX_FREE;
  hex_char_t nxt;
  result_t parsed;
  result_t due;

  intel_hex_record_loader dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_in_i    (char_in),
    .line_start_i (line_start),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .write_addr_o (write_addr),
    .write_data_o (write_data),
    .rec_type_o   (rec_type)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] nibble_value(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch - "0";
    if (ch >= "A" && ch <= "F") return ch - "A" + 8'd10;
    return ch - "a" + 8'd10;
  endfunction

  function automatic bit parse_char(input logic [7:0] ch, input logic first,
                                    output result_t res);
    logic [9:0]  p;
    logic [7:0]  nib;
    logic [7:0]  byte_v;
    logic [16:0] idx;
    bit          hit;
    hit = 1'b0;
    res = '0;
    if (first) begin
      line_pos = '0;
      rec_count = '0;
      rec_addr = '0;
      cur_type = '0;
      high_nib = '0;
    end
    p = line_pos;
    if (p == PosIdle || p >= PosEnd) return 1'b0;
    nib = nibble_value(ch);
    if (p == 10'd0) begin
      if (ch != StartCode) begin
        hit = 1'b1;
        res.kind = KIND_NO_START;
      end
    end else if (p[0]) begin
      high_nib = nib;
    end else begin
      byte_v = {high_nib[3:0], 4'h0} | nib;
      case (p)
        10'd2: rec_count = byte_v;
        10'd4: rec_addr = {byte_v, 8'h00};
        10'd6: rec_addr = rec_addr | {8'h00, byte_v};
        10'd8: begin
          cur_type = byte_v;
          if (byte_v == TypeEof) begin
            hit = 1'b1;
            res.kind = KIND_EOF;
          end else if (byte_v > TypeEof && byte_v <= TypeLoMax) begin
            hit = 1'b1;
            res.kind = KIND_UNSUPP;
          end else if (byte_v != TypeData) begin
            hit = 1'b1;
            res.kind = KIND_UNKNOWN;
          end
        end
        default: begin
          idx = 17'((p - PosData - 10'd1) >> 1);
          if (cur_type == TypeData && idx < {9'd0, rec_count}) begin
            hit = 1'b1;
            res.kind = KIND_WRITE;
            res.write_addr = {1'b0, rec_addr} + idx;
            res.write_data = byte_v;
          end
        end
      endcase
    end
    res.rec_type = cur_type;
    line_pos = p + 10'd1;
    return hit;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return "0" + n;
    return (lower ? "a" : "A") + n - 8'd10;
  endfunction

  task automatic add_char(input logic [7:0] ch, input logic first);
    hex_char_t it;
    it.ch = ch;
    it.first = first;
    line_chars.push_back(it);
    n_queued++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == 0);
  endtask

  task automatic put_hex(ref logic [7:0] q[$], input logic [7:0] b);
    bit lower;
    lower = $urandom_range(0, 1);
    q.push_back(stray_ok && $urandom_range(0, 39) == 0 ? 8'($urandom_range(0, 255))
                                                       : hex_digit(b[7:4], lower));
    q.push_back(stray_ok && $urandom_range(0, 39) == 0 ? 8'($urandom_range(0, 255))
                                                       : hex_digit(b[3:0], lower));
  endtask

  task automatic add_random_line(input bit full_len);
    logic [7:0]  text[$];
    logic [7:0]  cnt;
    logic [7:0]  typ;
    logic [7:0]  lead;
    logic [15:0] adr;
    int          n_data;
    int          cut;
    int          r;
    r = $urandom_range(0, 99);
    cnt = r < 60 ? 8'($urandom_range(0, 6)) :
          r < 90 ? 8'($urandom_range(7, 24)) : 8'($urandom_range(200, 255));
    adr = $urandom_range(0, 4) == 0 ? 16'hFF00 | 16'($urandom_range(0, 255))
                                    : 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    typ = r < 55 ? TypeData : r < 65 ? TypeEof :
          r < 80 ? 8'($urandom_range(2, 5)) : 8'($urandom_range(0, 255));
    lead = $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : StartCode;
    if (cnt > 8'd24) n_data = $urandom_range(0, 6);
    else if ($urandom_range(0, 6) == 0) n_data = $urandom_range(0, cnt);
    else n_data = cnt;
    if (full_len) begin
      cnt = 8'hFF;
      typ = TypeData;
      lead = StartCode;
      n_data = 255;
    end
    text.push_back(lead);
    put_hex(text, cnt);
    put_hex(text, adr[15:8]);
    put_hex(text, adr[7:0]);
    put_hex(text, typ);
    for (int i = 0; i < n_data; i++) put_hex(text, 8'($urandom_range(0, 255)));
    put_hex(text, 8'($urandom_range(0, 255)));
    r = full_len ? 6 : $urandom_range(0, 2);
    for (int i = 0; i < r; i++) text.push_back(8'($urandom_range(0, 255)));
    cut = text.size();
    if (!full_len && $urandom_range(0, 19) == 0) cut = $urandom_range(1, text.size());
    for (int i = 0; i < cut; i++) add_char(text[i], i == 0);
  endtask

  // driver: burst/gap pacing, predict on every accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      char_in <= 8'h00;
      line_start <= 1'b0;
      line_pos = PosIdle;
      rec_count = '0;
      rec_addr = '0;
      cur_type = '0;
      high_nib = '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        n_accepted++;
        if (parse_char(char_in, line_start, parsed)) record_events.push_back(parsed);
        holding = 1'b0;
      end else begin
        holding = in_valid;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_chars.size() > 0) begin
          nxt = line_chars.pop_front();
          in_valid <= 1'b1;
          char_in <= nxt.ch;
          line_start <= nxt.first;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(0, 7) == 0 ? 200 : $urandom_range(1, 40);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern in a randomly chosen mode
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_cyc = 0;
    end else begin
      stall_cyc++;
      if (stall_cyc % 150 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_COIN:  out_stall <= 1'($urandom_range(0, 1));
        RX_HEAVY: out_stall <= $urandom_range(0, 3) != 0;
        default:  out_stall <= (stall_cyc % 7) < 3;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (record_events.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: unexpected word kind %0d addr %05h data %02h type %02h",
                   $realtime, kind, write_addr, write_data, rec_type);
      end else begin
        due = record_events.pop_front();
        kind_seen[due.kind]++;
        if (kind !== due.kind || write_addr !== due.write_addr ||
            write_data !== due.write_data || rec_type !== due.rec_type) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: mismatch exp kind %0d addr %05h data %02h type %02h, got %0d %05h %02h %02h",
                     $realtime, due.kind, due.write_addr, due.write_data, due.rec_type,
                     kind, write_addr, write_data, rec_type);
        end
      end
    end
  end

  initial begin
    add_char(8'h80, 1'b0);
    add_text("X02FFFF0000ff");
    add_text(":00000000A7");
    add_text(":00000001");
    add_text(":00123405");
    add_text(":0120");
    add_text(":010000Fg");
    stray_ok = 1'b1;
    while (n_queued < 460) begin
      if ($urandom_range(0, 99) < 8) begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        add_random_line(1'b0);
      end
    end
    add_text(":00000001");

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_accepted != n_queued || record_events.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (record_events.size() != 0) n_bad++;
    $display("Parsed %0d characters into %0d writes, %0d missing start codes, %0d eof,",
             n_accepted, kind_seen[KIND_WRITE], kind_seen[KIND_NO_START], kind_seen[KIND_EOF]);
    $display("%0d unsupported and %0d unknown record types; %0d mismatches",
             kind_seen[KIND_UNSUPP], kind_seen[KIND_UNKNOWN], n_bad);
    if (n_bad == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout after %0d of %0d characters", n_accepted, n_queued);
    $display("Regression FAIL");
    $finish;
  end

endmodule
